### hw/rtl/pthspi_pkg.sv
// pthspi_pkg: request and response types, register map, codes and the iir filter step
// for the pth sensor spi register device; depends on nothing
`default_nettype none

package pthspi_pkg;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  spi_byte;
		logic [19:0] temp_code;
		logic [19:0] press_code;
		logic [15:0] hum_code;
	} req_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       write_error;
		logic       measured;
		logic [1:0] power_mode;
	} rsp_t;

	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_SLEEP  = 2'd1,
		MODE_NORMAL = 2'd2,
		MODE_FORCED = 2'd3
	} mode_t;

	localparam logic [1:0] CMD_BYTE    = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_TICK    = 2'd2;

	localparam logic [1:0] MREQ_SLEEP  = 2'b00;
	localparam logic [1:0] MREQ_NORMAL = 2'b11;

	localparam logic [7:0] SOFT_RESET_KEY = 8'hB6;
	localparam logic [7:0] CHIP_ID        = 8'h60;
	localparam logic [7:0] CONFIG_MASK    = 8'hFD;
	localparam logic [15:0] SKIPPED_CODE  = 16'h8000;
	localparam logic [19:0] WIDE_RESET    = 20'h80000;
	localparam logic [15:0] HUM_RESET     = 16'h8000;

	localparam logic [7:0] MAP_HUM_LSB    = 8'hFE;
	localparam logic [7:0] MAP_HUM_MSB    = 8'hFD;
	localparam logic [7:0] MAP_TEMP_XLSB  = 8'hFC;
	localparam logic [7:0] MAP_TEMP_LSB   = 8'hFB;
	localparam logic [7:0] MAP_TEMP_MSB   = 8'hFA;
	localparam logic [7:0] MAP_PRESS_XLSB = 8'hF9;
	localparam logic [7:0] MAP_PRESS_LSB  = 8'hF8;
	localparam logic [7:0] MAP_PRESS_MSB  = 8'hF7;
	localparam logic [7:0] MAP_CONFIG     = 8'hF5;
	localparam logic [7:0] MAP_CTRL_MEAS  = 8'hF4;
	localparam logic [7:0] MAP_STATUS     = 8'hF3;
	localparam logic [7:0] MAP_CTRL_HUM   = 8'hF2;
	localparam logic [7:0] MAP_RESET      = 8'hE0;
	localparam logic [7:0] MAP_ID         = 8'hD0;
	localparam logic [7:0] MAP_CAL0_FIRST = 8'h88;
	localparam logic [7:0] MAP_CAL0_LAST  = 8'hA1;
	localparam logic [7:0] MAP_CAL1_FIRST = 8'hE1;
	localparam logic [7:0] MAP_CAL1_LAST  = 8'hF0;

	// new = (old * (2^k - 1) + code) >> k, k = 0 passes the code through
	function automatic logic [19:0] iir_step(input logic [19:0] old, input logic [19:0] code,
			input logic [2:0] fsel);
		logic [2:0]  k;
		logic [24:0] prod;
		logic [24:0] acc;
		k = (fsel >= 3'd4) ? 3'd4 : fsel;
		prod = ({5'd0, old} << k) - {5'd0, old};
		acc = prod + {5'd0, code};
		acc = acc >> k;
		iir_step = acc[19:0];
	endfunction

endpackage

`default_nettype wire

### hw/rtl/pthspi_core.sv
// pthspi_core: register file, spi address/data decode and power mode machine
// depends on pthspi_pkg; state moves only on advance
`default_nettype none

module pthspi_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire pthspi_pkg::req_t  req,
	output pthspi_pkg::rsp_t       rsp
);

	logic                phase_q, phase_n;
	logic                write_q, write_n;
	logic [7:0]          addr_q, addr_n;
	logic [7:0]          config_q, config_n;
	logic [7:0]          ctrl_meas_q, ctrl_meas_n;
	logic [7:0]          ctrl_hum_q, ctrl_hum_n;
	logic [19:0]         temp_q, temp_n;
	logic [19:0]         press_q, press_n;
	logic [15:0]         hum_q, hum_n;
	pthspi_pkg::mode_t   mode_q, mode_n, mode_tick;

	logic [7:0]          rd_addr;
	logic                rd_hit;
	logic [7:0]          rd_val;

	// mode machine next state for a tick
	always_comb begin
		mode_tick = mode_q;
		case (mode_q)
			pthspi_pkg::MODE_SLEEP: begin
				if (ctrl_meas_q[1:0] == pthspi_pkg::MREQ_NORMAL)
					mode_tick = pthspi_pkg::MODE_NORMAL;
				else if (ctrl_meas_q[1:0] != pthspi_pkg::MREQ_SLEEP)
					mode_tick = pthspi_pkg::MODE_FORCED;
				else
					mode_tick = pthspi_pkg::MODE_SLEEP;
			end
			pthspi_pkg::MODE_NORMAL: begin
				if (ctrl_meas_q[1:0] == pthspi_pkg::MREQ_SLEEP)
					mode_tick = pthspi_pkg::MODE_SLEEP;
				else if (ctrl_meas_q[1:0] == pthspi_pkg::MREQ_NORMAL)
					mode_tick = pthspi_pkg::MODE_NORMAL;
				else
					mode_tick = pthspi_pkg::MODE_FORCED;
			end
			pthspi_pkg::MODE_FORCED: mode_tick = pthspi_pkg::MODE_SLEEP;
			default: mode_tick = pthspi_pkg::MODE_OFF;
		endcase
	end

	// read map
	assign rd_addr = phase_q ? addr_q : {1'b1, req.spi_byte[6:0]};

	always_comb begin
		rd_hit = 1'b1;
		rd_val = '0;
		case (rd_addr)
			pthspi_pkg::MAP_HUM_LSB:    rd_val = hum_q[7:0];
			pthspi_pkg::MAP_HUM_MSB:    rd_val = hum_q[15:8];
			pthspi_pkg::MAP_TEMP_XLSB:  rd_val = {temp_q[3:0], 4'd0};
			pthspi_pkg::MAP_TEMP_LSB:   rd_val = temp_q[11:4];
			pthspi_pkg::MAP_TEMP_MSB:   rd_val = temp_q[19:12];
			pthspi_pkg::MAP_PRESS_XLSB: rd_val = {press_q[3:0], 4'd0};
			pthspi_pkg::MAP_PRESS_LSB:  rd_val = press_q[11:4];
			pthspi_pkg::MAP_PRESS_MSB:  rd_val = press_q[19:12];
			pthspi_pkg::MAP_CONFIG:     rd_val = config_q;
			pthspi_pkg::MAP_CTRL_MEAS:  rd_val = ctrl_meas_q;
			pthspi_pkg::MAP_STATUS:     rd_val = '0;
			pthspi_pkg::MAP_CTRL_HUM:   rd_val = ctrl_hum_q;
			pthspi_pkg::MAP_RESET:      rd_val = '0;
			pthspi_pkg::MAP_ID:         rd_val = pthspi_pkg::CHIP_ID;
			default: begin
				rd_hit = ((rd_addr >= pthspi_pkg::MAP_CAL0_FIRST)
					&& (rd_addr <= pthspi_pkg::MAP_CAL0_LAST))
					|| ((rd_addr >= pthspi_pkg::MAP_CAL1_FIRST)
					&& (rd_addr <= pthspi_pkg::MAP_CAL1_LAST));
			end
		endcase
	end

	// request decode and response
	always_comb begin
		logic do_read;
		logic soft_rst;
		do_read = 1'b0;
		soft_rst = 1'b0;
		phase_n = phase_q;
		write_n = write_q;
		addr_n = addr_q;
		config_n = config_q;
		ctrl_meas_n = ctrl_meas_q;
		ctrl_hum_n = ctrl_hum_q;
		temp_n = temp_q;
		press_n = press_q;
		hum_n = hum_q;
		mode_n = mode_q;
		rsp = '0;
		case (req.command)
			pthspi_pkg::CMD_BYTE: begin
				if (!phase_q) begin
					addr_n = rd_addr;
					write_n = !req.spi_byte[7];
					phase_n = 1'b1;
					do_read = req.spi_byte[7];
				end else if (write_q) begin
					phase_n = 1'b0;
					case (addr_q)
						pthspi_pkg::MAP_CONFIG:
							config_n = req.spi_byte & pthspi_pkg::CONFIG_MASK;
						pthspi_pkg::MAP_CTRL_HUM:  ctrl_hum_n = req.spi_byte;
						pthspi_pkg::MAP_CTRL_MEAS: ctrl_meas_n = req.spi_byte;
						pthspi_pkg::MAP_RESET:
							soft_rst = (req.spi_byte == pthspi_pkg::SOFT_RESET_KEY);
						default: rsp.write_error = 1'b1;
					endcase
				end else begin
					do_read = 1'b1;
				end
				if (do_read && rd_hit) begin
					rsp.read_byte = rd_val;
					addr_n = rd_addr + 8'd1;
				end
			end
			pthspi_pkg::CMD_RELEASE: phase_n = 1'b0;
			pthspi_pkg::CMD_TICK: begin
				mode_n = mode_tick;
				if (mode_tick == pthspi_pkg::MODE_FORCED)
					ctrl_meas_n[1:0] = 2'b00;
				if (mode_tick == pthspi_pkg::MODE_NORMAL
						|| mode_tick == pthspi_pkg::MODE_FORCED) begin
					rsp.measured = 1'b1;
					temp_n = (ctrl_meas_q[7:5] == 3'd0) ? {4'd0, pthspi_pkg::SKIPPED_CODE}
						: pthspi_pkg::iir_step(temp_q, req.temp_code, config_q[4:2]);
					press_n = (ctrl_meas_q[4:2] == 3'd0) ? {4'd0, pthspi_pkg::SKIPPED_CODE}
						: pthspi_pkg::iir_step(press_q, req.press_code, config_q[4:2]);
					hum_n = (ctrl_hum_q[2:0] == 3'd0) ? pthspi_pkg::SKIPPED_CODE
						: req.hum_code;
				end
			end
			default: ;
		endcase
		if (soft_rst) begin
			phase_n = 1'b0;
			write_n = 1'b0;
			addr_n = '0;
			config_n = '0;
			ctrl_meas_n = '0;
			ctrl_hum_n = '0;
			temp_n = pthspi_pkg::WIDE_RESET;
			press_n = pthspi_pkg::WIDE_RESET;
			hum_n = pthspi_pkg::HUM_RESET;
			mode_n = pthspi_pkg::MODE_SLEEP;
		end
		rsp.power_mode = 2'(mode_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			write_q <= 1'b0;
			addr_q <= '0;
			config_q <= '0;
			ctrl_meas_q <= '0;
			ctrl_hum_q <= '0;
			temp_q <= pthspi_pkg::WIDE_RESET;
			press_q <= pthspi_pkg::WIDE_RESET;
			hum_q <= pthspi_pkg::HUM_RESET;
			mode_q <= pthspi_pkg::MODE_SLEEP;
		end else if (advance) begin
			phase_q <= phase_n;
			write_q <= write_n;
			addr_q <= addr_n;
			config_q <= config_n;
			ctrl_meas_q <= ctrl_meas_n;
			ctrl_hum_q <= ctrl_hum_n;
			temp_q <= temp_n;
			press_q <= press_n;
			hum_q <= hum_n;
			mode_q <= mode_n;
		end
	end

	a_forced_ends: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req.command == pthspi_pkg::CMD_TICK && mode_q == pthspi_pkg::MODE_FORCED
		|=> mode_q == pthspi_pkg::MODE_SLEEP)
		else $error("forced mode did not fall back to sleep");

	a_forced_clears_req: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req.command == pthspi_pkg::CMD_TICK
		|=> mode_q != pthspi_pkg::MODE_FORCED || ctrl_meas_q[1:0] == 2'b00)
		else $error("mode request bits left set after forced entry");

	a_addr_mapped_half: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> addr_q[7])
		else $error("active address below 0x80 in data phase");

endmodule

`default_nettype wire

### hw/rtl/pth_sensor_spi_register_device.sv
// pth_sensor_spi_register_device: top level with input register and response register
// depends on pthspi_pkg and pthspi_core
`default_nettype none

// Takes one request per cycle while cmd_stall is low (spi byte, chip select release or
// measurement tick) and returns one response per request: the request is held in an input
// register, decoded against the register file and mode machine in one pass, and the
// response lands in an output register. Back pressure on the response side stalls the
// request side only when both registers are full.
// Reset leaves the device in sleep mode with the result registers at 0x80000 / 0x8000.
module pth_sensor_spi_register_device (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_stall,
	input  wire pthspi_pkg::req_t  cmd,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output pthspi_pkg::rsp_t       rsp
);

	logic              valid_s1;
	pthspi_pkg::req_t  req_s1;
	logic              valid_s2;
	pthspi_pkg::rsp_t  rsp_s2;
	pthspi_pkg::rsp_t  core_rsp;
	logic              out_free;
	logic              advance;

	assign out_free = !valid_s2 || !rsp_stall;
	assign advance = valid_s1 && out_free;
	assign cmd_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!cmd_stall)
				valid_s1 <= cmd_valid;
			if (out_free)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall)
			req_s1 <= cmd;
		if (advance)
			rsp_s2 <= core_rsp;
	end

	pthspi_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.req     (req_s1),
		.rsp     (core_rsp)
	);

	assign rsp_valid = valid_s2;
	assign rsp = rsp_s2;

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> valid_s1 && valid_s2)
		else $error("request stalled with a free register");

	a_never_off: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.power_mode != 2'(pthspi_pkg::MODE_OFF))
		else $error("power mode off reported");

	a_tick_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.measured |-> rsp.read_byte == 8'd0 && !rsp.write_error)
		else $error("measurement response carries spi data");

endmodule

`default_nettype wire

### test/pth_sensor_spi_register_device_test.sv
// testbench for pth_sensor_spi_register_device: directed and random spi byte, chip select
// and measurement tick requests checked by a predicting scoreboard; depends on pthspi_pkg and the top
module pth_sensor_spi_register_device_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pthspi_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [7:0] MAP_TOP = 8'hFF;
	localparam int ITEMS = 1700;
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 20;

	class sensor_scoreboard;
		bit data_phase;
		logic [8:0] cur_addr;
		bit writing;
		logic [7:0] config_r;
		logic [7:0] ctrl_meas_r;
		logic [7:0] ctrl_hum_r;
		logic [19:0] temp_r;
		logic [19:0] press_r;
		logic [15:0] hum_r;
		mode_t mode;
		rsp_t pending_rsp[$];
		int errors;
		int n_req;
		int n_rsp;
		int n_reads;
		int n_meas;
		int n_write_err;
		int n_soft_reset;

		function new();
			power_on();
		endfunction

		function void power_on();
			data_phase = 1'b0;
			cur_addr = '0;
			writing = 1'b0;
			config_r = '0;
			ctrl_meas_r = '0;
			ctrl_hum_r = '0;
			temp_r = WIDE_RESET;
			press_r = WIDE_RESET;
			hum_r = HUM_RESET;
			mode = MODE_SLEEP;
		endfunction

		function bit reg_value(input logic [8:0] a, output logic [7:0] v);
			v = '0;
			if (a[8])
				return 1'b0;
			if ((a[7:0] >= MAP_CAL0_FIRST && a[7:0] <= MAP_CAL0_LAST) ||
					(a[7:0] >= MAP_CAL1_FIRST && a[7:0] <= MAP_CAL1_LAST))
				return 1'b1;
			case (a[7:0])
				MAP_HUM_LSB: v = hum_r[7:0];
				MAP_HUM_MSB: v = hum_r[15:8];
				MAP_TEMP_XLSB: v = {temp_r[3:0], 4'h0};
				MAP_TEMP_LSB: v = temp_r[11:4];
				MAP_TEMP_MSB: v = temp_r[19:12];
				MAP_PRESS_XLSB: v = {press_r[3:0], 4'h0};
				MAP_PRESS_LSB: v = press_r[11:4];
				MAP_PRESS_MSB: v = press_r[19:12];
				MAP_CONFIG: v = config_r;
				MAP_CTRL_MEAS: v = ctrl_meas_r;
				MAP_CTRL_HUM: v = ctrl_hum_r;
				MAP_STATUS, MAP_RESET: v = '0;
				MAP_ID: v = CHIP_ID;
				default: return 1'b0;
			endcase
			return 1'b1;
		endfunction

		// iir step with coefficient 2, 4, 8 or 16 from config bits 4:2; a zero field passes the code through
		function logic [19:0] smooth(input logic [19:0] old, input logic [19:0] code);
			int unsigned c;
			case (config_r[4:2])
				3'd0: return code;
				3'd1: c = 2;
				3'd2: c = 4;
				3'd3: c = 8;
				default: c = 16;
			endcase
			return 20'((old * (c - 1) + code) / c);
		endfunction

		function mode_t next_mode();
			logic [1:0] want;
			want = ctrl_meas_r[1:0];
			case (mode)
				MODE_SLEEP:
					return (want == MREQ_NORMAL) ? MODE_NORMAL :
						(want == MREQ_SLEEP) ? MODE_SLEEP : MODE_FORCED;
				MODE_NORMAL:
					return (want == MREQ_SLEEP) ? MODE_SLEEP :
						(want == MREQ_NORMAL) ? MODE_NORMAL : MODE_FORCED;
				MODE_FORCED: return MODE_SLEEP;
				default: return MODE_OFF;
			endcase
		endfunction

		function void note_req(req_t r);
			rsp_t e;
			logic [7:0] v;
			bit wrote;
			e = '0;
			wrote = 1'b0;
			if (r.command != CMD_UNUSED)
				n_req++;
			case (r.command)
				CMD_BYTE: begin
					if (!data_phase) begin
						cur_addr = {1'b0, r.spi_byte | 8'h80};
						writing = !r.spi_byte[7];
						data_phase = 1'b1;
					end else if (writing) begin
						wrote = 1'b1;
						data_phase = 1'b0;
						case (cur_addr[7:0])
							MAP_CONFIG: config_r = r.spi_byte & CONFIG_MASK;
							MAP_CTRL_HUM: ctrl_hum_r = r.spi_byte;
							MAP_CTRL_MEAS: ctrl_meas_r = r.spi_byte;
							MAP_RESET: begin
								if (r.spi_byte == SOFT_RESET_KEY) begin
									power_on();
									n_soft_reset++;
								end
							end
							default: begin
								e.write_error = 1'b1;
								n_write_err++;
							end
						endcase
					end
					if (!wrote && !writing && reg_value(cur_addr, v)) begin
						e.read_byte = v;
						cur_addr = cur_addr + 9'd1;
						n_reads++;
					end
				end
				CMD_RELEASE: data_phase = 1'b0;
				CMD_TICK: begin
					mode = next_mode();
					if (mode == MODE_FORCED)
						ctrl_meas_r[1:0] = MREQ_SLEEP;
					if (mode == MODE_NORMAL || mode == MODE_FORCED) begin
						temp_r = (ctrl_meas_r[7:5] == 3'd0) ? {4'h0, SKIPPED_CODE} :
							smooth(temp_r, r.temp_code);
						press_r = (ctrl_meas_r[4:2] == 3'd0) ? {4'h0, SKIPPED_CODE} :
							smooth(press_r, r.press_code);
						hum_r = (ctrl_hum_r[2:0] == 3'd0) ? SKIPPED_CODE : r.hum_code;
						e.measured = 1'b1;
						n_meas++;
					end
				end
				default: ;
			endcase
			e.power_mode = mode;
			pending_rsp.push_back(e);
		endfunction

		function void cmp_field(string what, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s expected %h got %h", $time, what, want, got);
			end
		endfunction

		function void check_rsp(rsp_t got);
			rsp_t want;
			if (pending_rsp.size() == 0) begin
				errors++;
				$display("%0t: response %h with nothing expected", $time, got);
				return;
			end
			want = pending_rsp.pop_front();
			n_rsp++;
			cmp_field("read_byte", want.read_byte, got.read_byte);
			cmp_field("write_error", 8'(want.write_error), 8'(got.write_error));
			cmp_field("measured", 8'(want.measured), 8'(got.measured));
			cmp_field("power_mode", 8'(want.power_mode), 8'(got.power_mode));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	req_t cmd = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	sensor_scoreboard sb = new();
	bit calm = 1'b0;
	int stall_left = 0;
	int quiet_cycles = 0;
	int n_drains = 0;

	pth_sensor_spi_register_device dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_gap();
		if (calm || $urandom_range(0, 99) < 60)
			return 0;
		return pick_len();
	endfunction

	function automatic logic [19:0] rand_code();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return 20'($urandom);
		endcase
	endfunction

	function automatic req_t rand_req();
		req_t r;
		r.command = 2'($urandom);
		r.spi_byte = 8'($urandom);
		r.temp_code = 20'($urandom);
		r.press_code = 20'($urandom);
		r.hum_code = 16'($urandom);
		return r;
	endfunction

	function automatic bit is_writable(logic [7:0] a);
		logic [7:0] full;
		full = a | 8'h80;
		return full == MAP_CONFIG || full == MAP_CTRL_HUM || full == MAP_CTRL_MEAS ||
			full == MAP_RESET;
	endfunction

	function automatic logic [7:0] pick_addr();
		case ($urandom_range(0, 5))
			0: return MAP_PRESS_MSB + 8'($urandom_range(0, 8));
			1: return 8'($urandom_range(MAP_CTRL_HUM, MAP_TOP));
			2: return MAP_ID;
			3: return MAP_RESET;
			4: return $urandom_range(0, 1) ? 8'($urandom_range(MAP_CAL0_FIRST, MAP_CAL0_LAST)) :
				8'($urandom_range(MAP_CAL1_FIRST, MAP_CAL1_LAST));
			default: return 8'($urandom_range(128, 255));
		endcase
	endfunction

	task automatic put_req(req_t r);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			cmd <= rand_req();
			repeat (gap) @(negedge clk);
		end
		cmd <= r;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		sb.note_req(r);
	endtask

	task automatic spi_xfer(logic [7:0] b);
		req_t r;
		r = rand_req();
		r.command = CMD_BYTE;
		r.spi_byte = b;
		put_req(r);
	endtask

	task automatic cs_release();
		req_t r;
		r = rand_req();
		r.command = CMD_RELEASE;
		put_req(r);
	endtask

	task automatic meas_tick(logic [19:0] t, logic [19:0] p, logic [15:0] h);
		req_t r;
		r = rand_req();
		r.command = CMD_TICK;
		r.temp_code = t;
		r.press_code = p;
		r.hum_code = h;
		put_req(r);
	endtask

	task automatic reg_write(logic [7:0] a, logic [7:0] v);
		spi_xfer(a & 8'h7F);
		spi_xfer(v);
		if ($urandom_range(0, 1))
			cs_release();
	endtask

	task automatic reg_read(logic [7:0] a, int n);
		spi_xfer(a | 8'h80);
		repeat (n) spi_xfer(8'($urandom));
		cs_release();
	endtask

	task automatic wait_drained();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (sb.pending_rsp.size() != 0)
			@(posedge clk);
		n_drains++;
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 99) < 15) begin
			rsp_stall <= 1'b1;
			stall_left <= pick_len() - 1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_rsp(rsp);
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d responses outstanding", $time,
				quiet_cycles, sb.pending_rsp.size());
			$display("pth_sensor_spi_register_device_test NOT OK");
			$finish;
		end
	end

	initial begin
		int sel;
		logic [7:0] a;
		logic [7:0] v;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed
		reg_read(MAP_ID, 0);
		reg_write(MAP_CONFIG, 8'hFF);
		reg_write(MAP_CTRL_HUM, 8'h07);
		reg_write(MAP_CTRL_MEAS, 8'hFF);
		meas_tick('1, '1, '1);
		meas_tick('0, '0, '0);
		reg_read(MAP_PRESS_MSB, 8);
		reg_write(8'h00, 8'hA5);
		reg_write(MAP_RESET, 8'h00);
		begin
			req_t r;
			r = rand_req();
			r.command = CMD_UNUSED;
			put_req(r);
		end
		reg_write(MAP_RESET, SOFT_RESET_KEY);
		wait_drained();

		// random
		while (sb.n_req < ITEMS) begin
			if ($urandom_range(0, 59) == 0)
				calm = !calm;
			sel = $urandom_range(0, 99);
			if (sel < 22) begin
				case ($urandom_range(0, 2))
					0: reg_write(MAP_CONFIG, 8'($urandom));
					1: begin
						v = 8'($urandom);
						if ($urandom_range(0, 4) == 0)
							v[2:0] = '0;
						reg_write(MAP_CTRL_HUM, v);
					end
					default: begin
						v = 8'($urandom);
						if ($urandom_range(0, 4) == 0)
							v[7:5] = '0;
						if ($urandom_range(0, 4) == 0)
							v[4:2] = '0;
						reg_write(MAP_CTRL_MEAS, v);
					end
				endcase
			end else if (sel < 44) begin
				reg_read(pick_addr(), $urandom_range(0, 10));
			end else if (sel < 68) begin
				repeat ($urandom_range(1, 4))
					meas_tick(rand_code(), rand_code(), 16'(rand_code()));
			end else if (sel < 76) begin
				do a = 8'($urandom_range(0, 127)); while (is_writable(a));
				reg_write(a, 8'($urandom));
			end else if (sel < 80) begin
				reg_write(MAP_RESET,
					($urandom_range(0, 9) == 0) ? SOFT_RESET_KEY : 8'($urandom));
			end else if (sel < 96) begin
				if ($urandom_range(0, 1)) begin
					repeat ($urandom_range(1, 4)) put_req(rand_req());
				end else begin
					spi_xfer(8'($urandom));
					cs_release();
				end
			end else begin
				wait_drained();
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d requests and %0d responses: %0d register reads, %0d measurements",
			sb.n_req, sb.n_rsp, sb.n_reads, sb.n_meas);
		$display("%0d rejected writes, %0d soft resets, %0d full drains", sb.n_write_err,
			sb.n_soft_reset, n_drains);
		if (sb.errors == 0 && sb.pending_rsp.size() == 0)
			$display("pth_sensor_spi_register_device_test OK");
		else
			$display("pth_sensor_spi_register_device_test NOT OK");
		$finish;
	end
endmodule

### pth_sensor_spi_register_device.f
hw/rtl/pthspi_pkg.sv
hw/rtl/pthspi_core.sv
hw/rtl/pth_sensor_spi_register_device.sv
test/pth_sensor_spi_register_device_test.sv
